// ----- src/cfr_pkg.sv -----
// Shared types, codes and constants of the camera frame rotator.
package cfr_pkg;

   // Field and register types.
   typedef logic [2:0]          kind_type;
   typedef logic signed [15:0]  step_type;
   typedef logic [15:0]         scale_type;
   typedef logic signed [18:0]  vec_type;
   typedef logic signed [17:0]  vec_out_type;
   typedef logic signed [31:0]  point_type;
   typedef logic [2:0]          csr_index_type;
   typedef logic [31:0]         csr_data_type;
   typedef logic [4:0]          cnt_type;

   // Command codes carried in the kind field.
   localparam kind_type KIND_ROLL_POS  = 3'd0;
   localparam kind_type KIND_ROLL_NEG  = 3'd1;
   localparam kind_type KIND_PITCH_POS = 3'd2;
   localparam kind_type KIND_PITCH_NEG = 3'd3;
   localparam kind_type KIND_YAW_POS   = 3'd4;
   localparam kind_type KIND_YAW_NEG   = 3'd5;

   // Control register indexes.
   localparam csr_index_type REG_ANGLE_SCALE = 3'd0;
   localparam csr_index_type REG_EYE_X       = 3'd1;
   localparam csr_index_type REG_EYE_Y       = 3'd2;
   localparam csr_index_type REG_EYE_Z       = 3'd3;

   // Register reset values.
   localparam scale_type RST_ANGLE_SCALE = 16'd1144;
   localparam point_type RST_EYE_X       = 32'sd0;
   localparam point_type RST_EYE_Y       = 32'sd0;
   localparam point_type RST_EYE_Z       = 32'sd2621440;

   // Frame reset values in Q2.16.
   localparam vec_type VEC_ONE     = 19'sd65536;
   localparam vec_type VEC_ZERO    = 19'sd0;
   localparam vec_type VEC_NEG_ONE = -19'sd65536;

   // Angle constants in Q8.24.
   localparam logic [31:0]      TWO_PI_U   = 32'd105414357;
   localparam point_type        TWO_PI_Q   = 32'sd105414357;
   localparam point_type        PI_Q       = 32'sd52707179;
   localparam point_type        HALF_PI_Q  = 32'sd26353589;
   // Twenty-one turns, enough to lift any negative product above zero.
   localparam logic [31:0]      NEG_BIAS   = 32'd2213701497;
   // CORDIC start value, the inverse gain in Q2.30.
   localparam point_type        CORDIC_K   = 32'sd652032874;

   // Sequencer counter start and end values.
   localparam cnt_type REDUCE_FIRST = 5'd5;
   localparam cnt_type CORDIC_LAST  = 5'd23;
   localparam cnt_type ROT_LAST     = 5'd11;

   // Arctangent of 2^-i in Q8.24, rounded.
   function automatic point_type atan_q(input cnt_type idx);
      point_type r;
      begin
         case (idx)
            5'd0:    r = 32'sd13176795;
            5'd1:    r = 32'sd7778716;
            5'd2:    r = 32'sd4110060;
            5'd3:    r = 32'sd2086331;
            5'd4:    r = 32'sd1047214;
            5'd5:    r = 32'sd524117;
            5'd6:    r = 32'sd262123;
            5'd7:    r = 32'sd131069;
            5'd8:    r = 32'sd65536;
            5'd9:    r = 32'sd32768;
            5'd10:   r = 32'sd16384;
            5'd11:   r = 32'sd8192;
            5'd12:   r = 32'sd4096;
            5'd13:   r = 32'sd2048;
            5'd14:   r = 32'sd1024;
            5'd15:   r = 32'sd512;
            5'd16:   r = 32'sd256;
            5'd17:   r = 32'sd128;
            5'd18:   r = 32'sd64;
            5'd19:   r = 32'sd32;
            5'd20:   r = 32'sd16;
            5'd21:   r = 32'sd8;
            5'd22:   r = 32'sd4;
            5'd23:   r = 32'sd2;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- src/cfr_channels.sv -----
// Handshake channel interfaces for commands and frame results.
interface cfr_req_if;
   logic               valid;
   logic               ready;
   cfr_pkg::kind_type  kind;
   cfr_pkg::step_type  angle_step;

   modport source (output valid, output kind, output angle_step, input ready);
   modport sink   (input valid, input kind, input angle_step, output ready);
endinterface

interface cfr_rsp_if;
   logic                  valid;
   logic                  ready;
   cfr_pkg::vec_out_type  right_x;
   cfr_pkg::vec_out_type  right_y;
   cfr_pkg::vec_out_type  right_z;
   cfr_pkg::vec_out_type  upv_x;
   cfr_pkg::vec_out_type  upv_y;
   cfr_pkg::vec_out_type  upv_z;
   cfr_pkg::vec_out_type  fwd_x;
   cfr_pkg::vec_out_type  fwd_y;
   cfr_pkg::vec_out_type  fwd_z;
   cfr_pkg::point_type    look_x;
   cfr_pkg::point_type    look_y;
   cfr_pkg::point_type    look_z;

   modport source (output valid, input ready,
                   output right_x, output right_y, output right_z,
                   output upv_x, output upv_y, output upv_z,
                   output fwd_x, output fwd_y, output fwd_z,
                   output look_x, output look_y, output look_z);
   modport sink   (input valid, output ready,
                   input right_x, input right_y, input right_z,
                   input upv_x, input upv_y, input upv_z,
                   input fwd_x, input fwd_y, input fwd_z,
                   input look_x, input look_y, input look_z);
endinterface

// ----- src/camera_frame_rotator.sv -----
// Camera frame rotator: keeps right, up and forward vectors and the look-at center.
//
// Each command beat turns the camera by roll, pitch or yaw and returns one result beat
// holding the whole frame. Work runs through one sequencer: the step is scaled by
// angle_scale on the shared multiplier, reduced into one turn by six compare-subtract
// passes, folded into [-pi/2, pi/2], then a 24-step CORDIC gives cosine and sine. The
// same multiplier then forms the twelve products of the pair rotation, one per cycle,
// and pitch and yaw finish by setting the center to eye plus forward. An unused kind
// skips all of this and goes straight to the output register. The block is ready for
// a new command in the cycle after the result is loaded. The result sits in an output
// register, so the next command is accepted while a result waits for its sink.
module camera_frame_rotator (
   input  logic                    clock,
   input  logic                    reset,
   cfr_req_if.sink                 req_ch,
   cfr_rsp_if.source               rsp_ch,
   input  logic                    csr_we,
   input  cfr_pkg::csr_index_type  csr_index,
   input  cfr_pkg::csr_data_type   csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_ANGLE  = 11'b000_0000_0010,
      ST_BIAS   = 11'b000_0000_0100,
      ST_REDUCE = 11'b000_0000_1000,
      ST_FOLD   = 11'b000_0001_0000,
      ST_CORDIC = 11'b000_0010_0000,
      ST_ROUND  = 11'b000_0100_0000,
      ST_ROT    = 11'b000_1000_0000,
      ST_COMMIT = 11'b001_0000_0000,
      ST_LOOK   = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   // Saturate a rounded rotation result to the stored vector range.
   function automatic cfr_pkg::vec_type rnd_sat(input logic signed [37:0] acc);
      logic signed [37:0] sum;
      logic signed [21:0] r;
      begin
         sum = acc + 38'sd32768;
         r   = sum[37:16];
         if (r > 22'sd262143)
            return 19'sd262143;
         else if (r < -22'sd262144)
            return -19'sd262144;
         else
            return r[18:0];
      end
   endfunction

   // Saturate a stored vector component to the output range.
   function automatic cfr_pkg::vec_out_type out_sat(input cfr_pkg::vec_type v);
      begin
         if (v > 19'sd131071)
            return 18'sd131071;
         else if (v < -19'sd131072)
            return -18'sd131072;
         else
            return v[17:0];
      end
   endfunction

   // Eye plus forward, saturated to 32 bits.
   function automatic cfr_pkg::point_type look_sat(input cfr_pkg::point_type eye,
                                                   input cfr_pkg::vec_type f);
      logic signed [32:0] sum;
      begin
         sum = {eye[31], eye} + {{14{f[18]}}, f};
         if (sum > 33'sd2147483647)
            return 32'sh7FFF_FFFF;
         else if (sum < -33'sd2147483648)
            return 32'sh8000_0000;
         else
            return sum[31:0];
      end
   endfunction

   // Control state.
   state_type           state_ff, state_in;
   cfr_pkg::cnt_type    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Registers and frame state.
   cfr_pkg::scale_type  scale_ff;
   cfr_pkg::point_type  eye_ff [3];
   cfr_pkg::vec_type    right_ff [3];
   cfr_pkg::vec_type    up_ff [3];
   cfr_pkg::vec_type    fwd_ff [3];
   cfr_pkg::point_type  look_ff [3];

   // Working registers.
   cfr_pkg::kind_type   kind_ff;
   cfr_pkg::step_type   step_ff;
   logic signed [32:0]  angle_ff, angle_in;
   logic [31:0]         red_ff, red_in;
   logic                neg_ff;
   cfr_pkg::point_type  x_ff, y_ff, z_ff;
   cfr_pkg::point_type  x_in, y_in, z_in;
   logic signed [17:0]  cos_ff, sin_ff;
   logic signed [37:0]  acc_ff [6];
   logic signed [37:0]  acc_in;

   // Output registers.
   cfr_pkg::vec_out_type out_right_ff [3];
   cfr_pkg::vec_out_type out_up_ff [3];
   cfr_pkg::vec_out_type out_fwd_ff [3];
   cfr_pkg::point_type   out_look_ff [3];

   logic                accept;
   logic                load_out;
   logic                is_pitch, is_yaw, dir_neg;
   logic [31:0]         red_step;
   cfr_pkg::point_type  t_wrap, z_fold;
   logic                neg_fold;
   cfr_pkg::point_type  dx, dy, atan_v;
   logic signed [32:0]  xr_sum, yr_sum;
   logic signed [17:0]  cos_raw, sin_raw;
   logic [1:0]          comp;
   logic [2:0]          acc_idx;
   logic                which, term;
   cfr_pkg::vec_type    p_k, q_k, mul_a;
   logic signed [17:0]  mul_b;
   logic signed [36:0]  prod;
   cfr_pkg::vec_type    new_p [3];
   cfr_pkg::vec_type    new_q [3];

   assign accept   = req_ch.valid && req_ch.ready;
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // Pair and direction decode.
   assign is_pitch = kind_ff inside {cfr_pkg::KIND_PITCH_POS, cfr_pkg::KIND_PITCH_NEG};
   assign is_yaw   = kind_ff inside {cfr_pkg::KIND_YAW_POS, cfr_pkg::KIND_YAW_NEG};
   assign dir_neg  = kind_ff inside {cfr_pkg::KIND_ROLL_NEG, cfr_pkg::KIND_PITCH_POS,
                                     cfr_pkg::KIND_YAW_NEG};

   // Scaled angle from the shared multiplier, wrap bias and turn reduction.
   assign angle_in = prod[32:0];
   assign red_step = cfr_pkg::TWO_PI_U << cnt_ff[2:0];

   always_comb begin
      if (state_ff == ST_BIAS) begin
         red_in = angle_ff[32] ? (angle_ff[31:0] + cfr_pkg::NEG_BIAS) : angle_ff[31:0];
      end else if (red_ff >= red_step) begin
         red_in = red_ff - red_step;
      end else begin
         red_in = red_ff;
      end
   end

   // Move into [-pi, pi), then fold into [-pi/2, pi/2].
   always_comb begin
      if (red_ff >= $unsigned(cfr_pkg::PI_Q))
         t_wrap = $signed(red_ff) - cfr_pkg::TWO_PI_Q;
      else
         t_wrap = $signed(red_ff);
      if (t_wrap > cfr_pkg::HALF_PI_Q) begin
         z_fold   = t_wrap - cfr_pkg::PI_Q;
         neg_fold = 1'b1;
      end else if (t_wrap < -cfr_pkg::HALF_PI_Q) begin
         z_fold   = t_wrap + cfr_pkg::PI_Q;
         neg_fold = 1'b1;
      end else begin
         z_fold   = t_wrap;
         neg_fold = 1'b0;
      end
   end

   // One CORDIC step per cycle.
   assign dx     = y_ff >>> cnt_ff;
   assign dy     = x_ff >>> cnt_ff;
   assign atan_v = cfr_pkg::atan_q(cnt_ff);

   always_comb begin
      if (!z_ff[31]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_v;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_v;
      end
   end

   // Round cosine and sine from Q2.30 to Q1.16.
   assign xr_sum  = {x_ff[31], x_ff} + 33'sd8192;
   assign yr_sum  = {y_ff[31], y_ff} + 33'sd8192;
   assign cos_raw = xr_sum[31:14];
   assign sin_raw = yr_sum[31:14];

   // Rotation step: component, target vector and product term from the counter.
   assign comp    = cnt_ff[3:2];
   assign acc_idx = cnt_ff[3:1];
   assign which   = cnt_ff[1];
   assign term    = cnt_ff[0];

   always_comb begin
      if (is_pitch) begin
         p_k = up_ff[comp];
         q_k = fwd_ff[comp];
      end else if (is_yaw) begin
         p_k = right_ff[comp];
         q_k = fwd_ff[comp];
      end else begin
         p_k = right_ff[comp];
         q_k = up_ff[comp];
      end
   end

   // Shared multiplier: step times scale while scaling, else the pair products.
   assign mul_a  = (state_ff == ST_ANGLE) ? $signed({{3{step_ff[15]}}, step_ff}) :
                   ((which ^ term) ? q_k : p_k);
   assign mul_b  = (state_ff == ST_ANGLE) ? $signed({2'b00, scale_ff}) :
                   (!term ? cos_ff : (which ? -sin_ff : sin_ff));
   assign prod   = mul_a * mul_b;
   assign acc_in = term ? (acc_ff[acc_idx] + {prod[36], prod}) : {prod[36], prod};

   // Rounded new pair values.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         new_p[k] = rnd_sat(acc_ff[2 * k]);
         new_q[k] = rnd_sat(acc_ff[2 * k + 1]);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready)
         rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = (req_ch.kind > cfr_pkg::KIND_YAW_NEG) ? ST_OUT : ST_ANGLE;
         end
         ST_ANGLE: begin
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            state_in = ST_REDUCE;
            cnt_in   = cfr_pkg::REDUCE_FIRST;
         end
         ST_REDUCE: begin
            if (cnt_ff == '0)
               state_in = ST_FOLD;
            else
               cnt_in = cnt_ff - 5'd1;
         end
         ST_FOLD: begin
            state_in = ST_CORDIC;
            cnt_in   = '0;
         end
         ST_CORDIC: begin
            if (cnt_ff == cfr_pkg::CORDIC_LAST) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_ROUND: begin
            state_in = ST_ROT;
            cnt_in   = '0;
         end
         ST_ROT: begin
            if (cnt_ff == cfr_pkg::ROT_LAST)
               state_in = ST_COMMIT;
            else
               cnt_in = cnt_ff + 5'd1;
         end
         ST_COMMIT: begin
            state_in = (is_pitch || is_yaw) ? ST_LOOK : ST_OUT;
         end
         ST_LOOK: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= cfr_pkg::RST_ANGLE_SCALE;
         eye_ff[0] <= cfr_pkg::RST_EYE_X;
         eye_ff[1] <= cfr_pkg::RST_EYE_Y;
         eye_ff[2] <= cfr_pkg::RST_EYE_Z;
      end else if (csr_we) begin
         case (csr_index)
            cfr_pkg::REG_ANGLE_SCALE: scale_ff  <= csr_wdata[15:0];
            cfr_pkg::REG_EYE_X:       eye_ff[0] <= csr_wdata;
            cfr_pkg::REG_EYE_Y:       eye_ff[1] <= csr_wdata;
            cfr_pkg::REG_EYE_Z:       eye_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Frame state: commit the rotated pair, then the center.
   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff <= '{cfr_pkg::VEC_ONE, cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ZERO};
         up_ff    <= '{cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ONE, cfr_pkg::VEC_ZERO};
         fwd_ff   <= '{cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ZERO, cfr_pkg::VEC_NEG_ONE};
         look_ff  <= '{32'sd0, 32'sd0, 32'sd0};
      end else if (state_ff == ST_COMMIT) begin
         if (is_pitch) begin
            up_ff  <= new_p;
            fwd_ff <= new_q;
         end else if (is_yaw) begin
            right_ff <= new_p;
            fwd_ff   <= new_q;
         end else begin
            right_ff <= new_p;
            up_ff    <= new_q;
         end
      end else if (state_ff == ST_LOOK) begin
         for (int k = 0; k < 3; k++)
            look_ff[k] <= look_sat(eye_ff[k], fwd_ff[k]);
      end
   end

   // Datapath working registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_ff <= req_ch.kind;
               step_ff <= req_ch.angle_step;
            end
         end
         ST_ANGLE: begin
            angle_ff <= angle_in;
         end
         ST_BIAS, ST_REDUCE: begin
            red_ff <= red_in;
         end
         ST_FOLD: begin
            x_ff   <= cfr_pkg::CORDIC_K;
            y_ff   <= 32'sd0;
            z_ff   <= z_fold;
            neg_ff <= neg_fold;
         end
         ST_CORDIC: begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end
         ST_ROUND: begin
            cos_ff <= neg_ff ? -cos_raw : cos_raw;
            sin_ff <= (neg_ff ^ dir_neg) ? -sin_raw : sin_raw;
         end
         ST_ROT: begin
            acc_ff[acc_idx] <= acc_in;
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int k = 0; k < 3; k++) begin
            out_right_ff[k] <= out_sat(right_ff[k]);
            out_up_ff[k]    <= out_sat(up_ff[k]);
            out_fwd_ff[k]   <= out_sat(fwd_ff[k]);
            out_look_ff[k]  <= look_ff[k];
         end
      end
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.right_x = out_right_ff[0];
   assign rsp_ch.right_y = out_right_ff[1];
   assign rsp_ch.right_z = out_right_ff[2];
   assign rsp_ch.upv_x   = out_up_ff[0];
   assign rsp_ch.upv_y   = out_up_ff[1];
   assign rsp_ch.upv_z   = out_up_ff[2];
   assign rsp_ch.fwd_x   = out_fwd_ff[0];
   assign rsp_ch.fwd_y   = out_fwd_ff[1];
   assign rsp_ch.fwd_z   = out_fwd_ff[2];
   assign rsp_ch.look_x  = out_look_ff[0];
   assign rsp_ch.look_y  = out_look_ff[1];
   assign rsp_ch.look_z  = out_look_ff[2];

   // A command beat keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("command taken on two consecutive cycles");

   // The turn reduction leaves less than one full turn.
   a_reduce_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (red_ff < cfr_pkg::TWO_PI_U))
      else $error("angle not reduced below one turn");

   // The CORDIC starts inside its convergence range.
   a_cordic_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC && cnt_ff == '0) |->
      (z_ff <= cfr_pkg::HALF_PI_Q && z_ff >= -cfr_pkg::HALF_PI_Q))
      else $error("CORDIC angle outside half range");

   // Roll never moves the center.
   a_look_turn_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |->
      (kind_ff != cfr_pkg::KIND_ROLL_POS && kind_ff != cfr_pkg::KIND_ROLL_NEG))
      else $error("center update on a roll command");

   // A finished frame waits while the previous result is still held.
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_OUT))
      else $error("result overwritten before it was taken");

endmodule

// ----- bench/cfr_frame_checker.sv -----
// Frame checker: watches the command, result and register ports, predicts each frame and compares.
`timescale 1ns / 100ps

module cfr_frame_checker (
   input  logic                    clock,
   input  logic                    reset,
   cfr_req_if                      req_ch,
   cfr_rsp_if                      rsp_ch,
   input  logic                    csr_we,
   input  cfr_pkg::csr_index_type  csr_index,
   input  cfr_pkg::csr_data_type   csr_wdata,
   output int                      fail_count,
   output int                      pending_beats,
   output int                      checked_beats
);

   // Angle constants in Q8.24 and the CORDIC start value in Q2.30.
   localparam longint TURN_Q         = 64'sd105414357;
   localparam longint HALF_TURN_Q    = 64'sd52707179;
   localparam longint QUARTER_TURN_Q = 64'sd26353589;
   localparam longint GAIN_INV       = 64'sd652032874;
   localparam int     ROTATION_STEPS = 24;

   // Clamp bounds for the frame state, the output fields and the center.
   localparam longint STATE_HI = 64'sd262143;
   localparam longint STATE_LO = -64'sd262144;
   localparam longint OUT_HI   = 64'sd131071;
   localparam longint OUT_LO   = -64'sd131072;
   localparam longint POINT_HI = 64'sd2147483647;
   localparam longint POINT_LO = -64'sd2147483648;

   // One frame beat as it leaves the block.
   typedef struct {
      cfr_pkg::vec_out_type  axis [9];
      cfr_pkg::point_type    look [3];
   } frame_beat_type;

   longint arctan_q [ROTATION_STEPS] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   string field_names [12] = '{
      "right_x", "right_y", "right_z", "upv_x", "upv_y", "upv_z",
      "fwd_x", "fwd_y", "fwd_z", "look_x", "look_y", "look_z"
   };

   // Predicted camera state and register copies.
   cfr_pkg::scale_type  scale_q;
   cfr_pkg::point_type  eye_pos  [3];
   cfr_pkg::vec_type    right_v  [3];
   cfr_pkg::vec_type    up_v     [3];
   cfr_pkg::vec_type    fwd_v    [3];
   cfr_pkg::point_type  center_v [3];

   frame_beat_type  expected_frames [$];
   int              mismatches;
   int              compared;

   function automatic cfr_pkg::vec_type clamp_state(input longint v);
      if (v > STATE_HI) return cfr_pkg::vec_type'(STATE_HI);
      if (v < STATE_LO) return cfr_pkg::vec_type'(STATE_LO);
      return cfr_pkg::vec_type'(v);
   endfunction

   function automatic cfr_pkg::vec_out_type clamp_out(input cfr_pkg::vec_type v);
      if (v > OUT_HI) return cfr_pkg::vec_out_type'(OUT_HI);
      if (v < OUT_LO) return cfr_pkg::vec_out_type'(OUT_LO);
      return cfr_pkg::vec_out_type'(v);
   endfunction

   // Wrap the angle into one turn, fold it into the right half plane and run the CORDIC.
   function automatic void derive_cos_sin(input longint angle, output longint cos_q,
                                          output longint sin_q);
      longint t;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit     mirrored;
      t = angle % TURN_Q;
      if (t < 0) t += TURN_Q;
      if (t >= HALF_TURN_Q) t -= TURN_Q;
      mirrored = 1'b0;
      if (t > QUARTER_TURN_Q) begin
         t -= HALF_TURN_Q;
         mirrored = 1'b1;
      end else if (t < -QUARTER_TURN_Q) begin
         t += HALF_TURN_Q;
         mirrored = 1'b1;
      end
      x = GAIN_INV;
      y = 0;
      z = t;
      for (int i = 0; i < ROTATION_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_q[i];
         end else begin
            x += dx;
            y -= dy;
            z += arctan_q[i];
         end
      end
      cos_q = (x + 8192) >>> 14;
      sin_q = (y + 8192) >>> 14;
      if (mirrored) begin
         cos_q = -cos_q;
         sin_q = -sin_q;
      end
   endfunction

   // Rotate the chosen pair of axes from their old values and, for pitch and yaw, move the center.
   function automatic void apply_command(input cfr_pkg::kind_type k,
                                         input cfr_pkg::step_type st);
      longint c;
      longint s;
      longint p [3];
      longint q [3];
      cfr_pkg::vec_type np [3];
      cfr_pkg::vec_type nq [3];
      derive_cos_sin(longint'(st) * longint'(scale_q), c, s);
      if (k inside {cfr_pkg::KIND_ROLL_NEG, cfr_pkg::KIND_PITCH_POS, cfr_pkg::KIND_YAW_NEG})
         s = -s;
      for (int i = 0; i < 3; i++) begin
         case (k)
            cfr_pkg::KIND_ROLL_POS, cfr_pkg::KIND_ROLL_NEG: begin
               p[i] = right_v[i];
               q[i] = up_v[i];
            end
            cfr_pkg::KIND_PITCH_POS, cfr_pkg::KIND_PITCH_NEG: begin
               p[i] = up_v[i];
               q[i] = fwd_v[i];
            end
            default: begin
               p[i] = right_v[i];
               q[i] = fwd_v[i];
            end
         endcase
         np[i] = clamp_state((p[i] * c + q[i] * s + 32768) >>> 16);
         nq[i] = clamp_state((q[i] * c - p[i] * s + 32768) >>> 16);
         case (k)
            cfr_pkg::KIND_ROLL_POS, cfr_pkg::KIND_ROLL_NEG: begin
               right_v[i] = np[i];
               up_v[i] = nq[i];
            end
            cfr_pkg::KIND_PITCH_POS, cfr_pkg::KIND_PITCH_NEG: begin
               up_v[i] = np[i];
               fwd_v[i] = nq[i];
            end
            default: begin
               right_v[i] = np[i];
               fwd_v[i] = nq[i];
            end
         endcase
      end
      // Pitch and yaw put the center one forward step in front of the eye.
      if (k >= cfr_pkg::KIND_PITCH_POS) begin
         for (int i = 0; i < 3; i++) begin
            c = longint'(eye_pos[i]) + longint'(fwd_v[i]);
            if (c > POINT_HI) c = POINT_HI;
            if (c < POINT_LO) c = POINT_LO;
            center_v[i] = cfr_pkg::point_type'(c);
         end
      end
   endfunction

   // Per-edge bookkeeping: compare results first, then registers, then new commands.
   always @(posedge clock) begin
      frame_beat_type got;
      frame_beat_type want;
      longint         e_val;
      longint         a_val;
      if (reset) begin
         scale_q = cfr_pkg::RST_ANGLE_SCALE;
         eye_pos[0] = cfr_pkg::RST_EYE_X;
         eye_pos[1] = cfr_pkg::RST_EYE_Y;
         eye_pos[2] = cfr_pkg::RST_EYE_Z;
         right_v = '{cfr_pkg::VEC_ONE, cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ZERO};
         up_v = '{cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ONE, cfr_pkg::VEC_ZERO};
         fwd_v = '{cfr_pkg::VEC_ZERO, cfr_pkg::VEC_ZERO, cfr_pkg::VEC_NEG_ONE};
         center_v = '{32'sd0, 32'sd0, 32'sd0};
         expected_frames.delete();
         mismatches = 0;
         compared = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.axis = '{rsp_ch.right_x, rsp_ch.right_y, rsp_ch.right_z,
                         rsp_ch.upv_x, rsp_ch.upv_y, rsp_ch.upv_z,
                         rsp_ch.fwd_x, rsp_ch.fwd_y, rsp_ch.fwd_z};
            got.look = '{rsp_ch.look_x, rsp_ch.look_y, rsp_ch.look_z};
            if (expected_frames.size() == 0) begin
               $display("%0t: frame beat arrived with no command outstanding", $time);
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               compared++;
               for (int i = 0; i < 12; i++) begin
                  if (i < 9) begin
                     e_val = want.axis[i];
                     a_val = got.axis[i];
                  end else begin
                     e_val = want.look[i - 9];
                     a_val = got.look[i - 9];
                  end
                  if (e_val != a_val) begin
                     $display("%0t: %s expected %0d, got %0d", $time, field_names[i],
                              e_val, a_val);
                     mismatches++;
                  end
               end
            end
         end

         if (csr_we) begin
            case (csr_index)
               cfr_pkg::REG_ANGLE_SCALE: scale_q = csr_wdata[15:0];
               cfr_pkg::REG_EYE_X:       eye_pos[0] = cfr_pkg::point_type'(csr_wdata);
               cfr_pkg::REG_EYE_Y:       eye_pos[1] = cfr_pkg::point_type'(csr_wdata);
               cfr_pkg::REG_EYE_Z:       eye_pos[2] = cfr_pkg::point_type'(csr_wdata);
               default:                  ;
            endcase
         end

         // Unused kinds leave the frame alone and still return it.
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind <= cfr_pkg::KIND_YAW_NEG)
               apply_command(req_ch.kind, req_ch.angle_step);
            for (int i = 0; i < 3; i++) begin
               want.axis[i] = clamp_out(right_v[i]);
               want.axis[3 + i] = clamp_out(up_v[i]);
               want.axis[6 + i] = clamp_out(fwd_v[i]);
               want.look[i] = center_v[i];
            end
            expected_frames.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending_beats <= expected_frames.size();
      checked_beats <= compared;
   end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, command and register stimulus, and the final verdict.
`timescale 1ns / 100ps

module tb_top;

   // Codes the block leaves unused, reached on purpose.
   localparam cfr_pkg::kind_type      KIND_SPARE_LO = 3'd6;
   localparam cfr_pkg::kind_type      KIND_SPARE_HI = 3'd7;
   localparam cfr_pkg::csr_index_type REG_SPARE_LO  = 3'd4;
   localparam cfr_pkg::csr_index_type REG_SPARE_HI  = 3'd7;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 200;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 64;

   localparam cfr_pkg::step_type     STEP_MAX     = 16'sh7FFF;
   localparam cfr_pkg::step_type     STEP_MIN     = 16'sh8000;
   localparam cfr_pkg::step_type     QUARTER_STEP = 16'sd23040;
   localparam cfr_pkg::csr_data_type EYE_MAX      = 32'h7FFF_FFFF;
   localparam cfr_pkg::csr_data_type EYE_MIN      = 32'h8000_0000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   cfr_pkg::csr_index_type  csr_index;
   cfr_pkg::csr_data_type   csr_wdata;

   int  fail_count;
   int  pending_beats;
   int  checked_beats;
   int  commands_sent = 0;
   int  settings_used = 1;
   int  stuck_cycles = 0;
   bit  idle_on = 1'b1;

   cfr_req_if req_ch ();
   cfr_rsp_if rsp_ch ();

   always #1 clock = ~clock;

   camera_frame_rotator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfr_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .checked_beats (checked_beats)
   );

   // Hold a command until it is taken; sometimes go quiet for a burst afterwards.
   task automatic send_command(input cfr_pkg::kind_type k, input cfr_pkg::step_type st);
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.angle_step <= st;
      do @(posedge clock); while (!req_ch.ready);
      commands_sent++;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // The write enable stays high across back-to-back writes; the caller lowers it.
   task automatic write_reg(input cfr_pkg::csr_index_type idx,
                            input cfr_pkg::csr_data_type data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Wait until every outstanding frame has come back and the block is quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load all four registers plus a write to an index the block must ignore.
   task automatic program_regs(input cfr_pkg::csr_data_type scale_word,
                               input cfr_pkg::csr_data_type ex,
                               input cfr_pkg::csr_data_type ey,
                               input cfr_pkg::csr_data_type ez);
      write_reg(cfr_pkg::REG_ANGLE_SCALE, scale_word);
      write_reg(cfr_pkg::REG_EYE_X, ex);
      write_reg(cfr_pkg::REG_EYE_Y, ey);
      write_reg(cfr_pkg::REG_EYE_Z, ez);
      write_reg(cfr_pkg::csr_index_type'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                $urandom);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Result sink: ready in random stretches, with stall bursts while idling is on.
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Watchdog on cycles where no beat and no register write moves.
   always @(posedge clock) begin
      if (reset || csr_we || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Main stimulus.
   initial begin
      cfr_pkg::kind_type      k;
      cfr_pkg::step_type      st;
      cfr_pkg::csr_data_type  scale_word;
      cfr_pkg::csr_data_type  eye_word [3];

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= cfr_pkg::REG_ANGLE_SCALE;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind <= cfr_pkg::KIND_ROLL_POS;
      req_ch.angle_step <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: every kind on the reset registers, quarter turns and step extremes.
      send_command(cfr_pkg::KIND_ROLL_POS, QUARTER_STEP);
      send_command(cfr_pkg::KIND_ROLL_NEG, QUARTER_STEP);
      send_command(cfr_pkg::KIND_PITCH_POS, QUARTER_STEP);
      send_command(cfr_pkg::KIND_PITCH_NEG, -QUARTER_STEP);
      send_command(cfr_pkg::KIND_YAW_POS, STEP_MAX);
      send_command(cfr_pkg::KIND_YAW_NEG, STEP_MIN);
      send_command(KIND_SPARE_LO, STEP_MAX);
      send_command(KIND_SPARE_HI, -16'sd1);
      send_command(cfr_pkg::KIND_ROLL_POS, 16'sd0);
      send_command(cfr_pkg::KIND_PITCH_POS, 16'sd1);
      send_command(cfr_pkg::KIND_YAW_POS, -16'sd1);
      send_command(cfr_pkg::KIND_ROLL_NEG, STEP_MIN);
      settle();

      // Directed: largest scale and an eye at the edges so the center clamps.
      program_regs({16'($urandom), 16'hFFFF}, EYE_MAX, EYE_MIN, 32'h7FFF_0000);
      send_command(cfr_pkg::KIND_PITCH_POS, STEP_MAX);
      send_command(cfr_pkg::KIND_YAW_NEG, STEP_MIN);
      send_command(cfr_pkg::KIND_ROLL_POS, 16'sd12345);
      send_command(cfr_pkg::KIND_PITCH_NEG, 16'sd0);
      send_command(cfr_pkg::KIND_YAW_POS, 16'sd1);
      send_command(KIND_SPARE_LO, 16'sd0);
      send_command(cfr_pkg::KIND_ROLL_NEG, -16'sd1);
      send_command(cfr_pkg::KIND_YAW_POS, STEP_MAX);
      settle();

      // Random phases, each under fresh register values.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0:       scale_word = {16'($urandom), 16'h0000};
            1:       scale_word = {16'($urandom), 16'hFFFF};
            2:       scale_word = {16'($urandom), cfr_pkg::RST_ANGLE_SCALE};
            default: scale_word = $urandom;
         endcase
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
               0:       eye_word[i] = EYE_MAX;
               1:       eye_word[i] = EYE_MIN;
               2:       eye_word[i] = cfr_pkg::csr_data_type'(
                                         int'($urandom_range(0, 'h7F_FFFF)) - 'h40_0000);
               default: eye_word[i] = $urandom;
            endcase
         end
         program_regs(scale_word, eye_word[0], eye_word[1], eye_word[2]);
         idle_on = (phase != RANDOM_PHASES - 1) && (phase % 3 != 2);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 9) == 0)
               k = cfr_pkg::kind_type'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else
               k = cfr_pkg::kind_type'($urandom_range(cfr_pkg::KIND_ROLL_POS,
                                                      cfr_pkg::KIND_YAW_NEG));
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                  st = cfr_pkg::step_type'(int'($urandom_range(0, 2047)) - 1024);
               17:      st = STEP_MAX;
               18:      st = STEP_MIN;
               19:      st = cfr_pkg::step_type'(int'($urandom_range(0, 2)) - 1);
               default: st = cfr_pkg::step_type'($urandom);
            endcase
            send_command(k, st);
         end
         settle();
      end

      // Leave room for any stray result before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d roll, pitch, yaw and unused commands under %0d register settings.",
               commands_sent, settings_used);
      $display("Compared %0d frame beats field by field; %0d mismatches.",
               checked_beats, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
